// File: design/linear_blend_skinning_unit_macros.svh
// assertion macros for the skinning unit
`ifndef LINEAR_BLEND_SKINNING_UNIT_MACROS_SVH
`define LINEAR_BLEND_SKINNING_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define LBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lbs_pkg.sv
// shared constants and arithmetic helpers of the skinning unit
package lbs_pkg;

    localparam int MAX_BONES_DEF = 256;
    localparam int WORDS_PER_BONE = 12;
    localparam int NUM_LANES = 4;
    localparam int PIPE_DEPTH = 5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SKIN = 1'b1;

    localparam logic [7:0] WORD_MARGIN = 8'd12;

    // saturate a signed value held in 40 bits to 32 bits
    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        logic signed [31:0] r;
        begin
            if (v > 40'sd2147483647)
            begin
                r = 32'sh7fffffff;
            end
            else if (v < -40'sd2147483648)
            begin
                r = 32'sh80000000;
            end
            else
            begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

// File: design/lbs_lane.sv
// one bone lane: palette copy, row transform and weighting
module lbs_lane
    import lbs_pkg::*;
#(
    parameter int MAX_BONES = MAX_BONES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [7:0]          wr_bone,
    input  logic [3:0]          wr_word,
    input  logic [31:0]         wr_data,
    input  logic                rd_en,
    input  logic [7:0]          rd_bone,
    input  logic [16:0]         rd_weight,
    input  logic signed [31:0]  px,
    input  logic signed [31:0]  py,
    input  logic signed [31:0]  pz,
    output logic signed [49:0]  term_x,
    output logic signed [49:0]  term_y,
    output logic signed [49:0]  term_z,
    output logic signed [49:0]  term_m
);

    localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    // thirteen word memories, one per palette word, so a bone reads in one access
    logic [31:0] mem [WORDS_PER_BONE+1][MAX_BONES];
    logic [31:0] rd_data [WORDS_PER_BONE+1];

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_ok;
    logic          rd_ok;

    assign wr_addr = AW'(wr_bone);
    assign rd_addr = AW'(rd_bone);
    assign wr_ok   = (32'(wr_bone) < 32'(MAX_BONES));
    assign rd_ok   = (32'(rd_bone) < 32'(MAX_BONES)) && (rd_weight != 17'd0);

    genvar g;
    generate
        for (g = 0; g <= WORDS_PER_BONE; g++)
        begin : g_word
            always_ff @(posedge clk)
            begin
                if (wr_en && wr_ok && (wr_word == 4'(g)))
                begin
                    mem[g][wr_addr] <= wr_data;
                end
                if (rd_en)
                begin
                    rd_data[g] <= mem[g][rd_addr];
                end
            end
        end
    endgenerate

    // stage 1 side registers: position, weight, use flag
    logic signed [31:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [16:0]        s1_w_reg;
    logic               s1_use_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_x_reg   <= px;
            s1_y_reg   <= py;
            s1_z_reg   <= pz;
            s1_w_reg   <= rd_weight;
            s1_use_reg <= rd_ok;
        end
    end

    // stage 2: nine products, truncated
    logic signed [47:0] s2_p_reg [9];
    logic signed [31:0] s2_t_reg [3];
    logic signed [31:0] s2_m_reg;
    logic [16:0]        s2_w_reg;
    logic               s2_use_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s2_p_reg[3*r]   <= 48'((64'(signed'(rd_data[4*r]))   * 64'(s1_x_reg)) >>> 16);
                s2_p_reg[3*r+1] <= 48'((64'(signed'(rd_data[4*r+1])) * 64'(s1_y_reg)) >>> 16);
                s2_p_reg[3*r+2] <= 48'((64'(signed'(rd_data[4*r+2])) * 64'(s1_z_reg)) >>> 16);
                s2_t_reg[r]     <= signed'(rd_data[4*r+3]);
            end
            s2_m_reg   <= signed'(rd_data[WORDS_PER_BONE]);
            s2_w_reg   <= s1_w_reg;
            s2_use_reg <= s1_use_reg;
        end
    end

    // stage 3: row sums, saturated
    logic signed [31:0] s3_row_reg [3];
    logic signed [31:0] s3_m_reg;
    logic [16:0]        s3_w_reg;
    logic               s3_use_reg;
    logic signed [49:0] rsum [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rsum[r] = 50'(s2_p_reg[3*r]) + 50'(s2_p_reg[3*r+1]) + 50'(s2_p_reg[3*r+2])
                    + 50'(s2_t_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (rsum[r] > 50'sd2147483647)
                begin
                    s3_row_reg[r] <= 32'sh7fffffff;
                end
                else if (rsum[r] < -50'sd2147483648)
                begin
                    s3_row_reg[r] <= 32'sh80000000;
                end
                else
                begin
                    s3_row_reg[r] <= rsum[r][31:0];
                end
            end
            s3_m_reg   <= s2_m_reg;
            s3_w_reg   <= s2_w_reg;
            s3_use_reg <= s2_use_reg;
        end
    end

    // stage 4: weighting, unused lane gives zero
    logic signed [49:0] wx, wy, wz, wm;
    logic signed [18:0] ws;

    assign ws = {2'b00, s3_w_reg};
    assign wx = 50'((51'(s3_row_reg[0]) * 51'(ws)) >>> 16);
    assign wy = 50'((51'(s3_row_reg[1]) * 51'(ws)) >>> 16);
    assign wz = 50'((51'(s3_row_reg[2]) * 51'(ws)) >>> 16);
    assign wm = 50'((51'(s3_m_reg) * 51'(ws)) >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_x <= '0;
            term_y <= '0;
            term_z <= '0;
            term_m <= '0;
        end
        else if (rd_en)
        begin
            term_x <= s3_use_reg ? wx : '0;
            term_y <= s3_use_reg ? wy : '0;
            term_z <= s3_use_reg ? wz : '0;
            term_m <= s3_use_reg ? wm : '0;
        end
    end

endmodule

// File: design/linear_blend_skinning_unit.sv
// top level of the four-bone skinning unit
// Usage: one input channel (in_valid/in_ready) carries load and vertex beats.
// A load beat (cmd 0) writes one palette word of bone bone_a, word bone_b
// (0..11 matrix, 12 margin) with pos_x; it gives no output beat.
// A vertex beat (cmd 1) gives one output beat (out_valid/out_ready) with the
// blended out_x, out_y, out_z and out_margin.
// Vertex beats pass read, product, row-sum, weighting and output registers.
// Throughput: one beat per cycle; four lanes each hold a copy of the palette
// in thirteen word-wide memories, so all four bones read in one access.
// The pipeline advances as a whole; when the receiver stalls it holds, and
// in_ready falls only while the output register is full and not taken.
// Reset clears the valid flags of the pipeline; palette contents are
// undefined until written, and no clearing pass runs.
// A load is visible to any vertex beat accepted after it.
module linear_blend_skinning_unit
    import lbs_pkg::*;
#(
    parameter int MAX_BONES = MAX_BONES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [16:0]        weight_a,
    input  logic [16:0]        weight_b,
    input  logic [16:0]        weight_c,
    input  logic [16:0]        weight_d,
    input  logic [7:0]         bone_a,
    input  logic [7:0]         bone_b,
    input  logic [7:0]         bone_c,
    input  logic [7:0]         bone_d,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_margin
);

    // whole pipeline moves when the output slot is free or being taken
    logic adv;
    logic in_fire;
    logic [PIPE_DEPTH-2:0] vld_reg;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign in_fire  = in_valid && in_ready;

    // palette write
    logic       wr_en;
    logic [3:0] wr_word;

    assign wr_en   = in_fire && (cmd == CMD_LOAD) && (bone_b <= WORD_MARGIN);
    assign wr_word = bone_b[3:0];

    logic [7:0]  lb [NUM_LANES];
    logic [16:0] lw [NUM_LANES];
    logic signed [49:0] tx [NUM_LANES];
    logic signed [49:0] ty [NUM_LANES];
    logic signed [49:0] tz [NUM_LANES];
    logic signed [49:0] tm [NUM_LANES];

    assign lb[0] = bone_a;
    assign lb[1] = bone_b;
    assign lb[2] = bone_c;
    assign lb[3] = bone_d;
    assign lw[0] = weight_a;
    assign lw[1] = weight_b;
    assign lw[2] = weight_c;
    assign lw[3] = weight_d;

    // lanes load their registers only on advance, through the rd_en enable
    genvar l;
    generate
        for (l = 0; l < NUM_LANES; l++)
        begin : g_lane
            lbs_lane #(.MAX_BONES(MAX_BONES)) u_lane
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (wr_en),
                .wr_bone   (bone_a),
                .wr_word   (wr_word),
                .wr_data   (pos_x),
                .rd_en     (adv),
                .rd_bone   (lb[l]),
                .rd_weight (lw[l]),
                .px        (pos_x),
                .py        (pos_y),
                .pz        (pos_z),
                .term_x    (tx[l]),
                .term_y    (ty[l]),
                .term_z    (tz[l]),
                .term_m    (tm[l])
            );
        end
    endgenerate

    // valid chain for vertex beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-3:0], in_fire && (cmd == CMD_SKIN)};
        end
    end

    // final blend, saturate into the output register
    logic signed [51:0] sx, sy, sz, sm;

    assign sx = 52'(tx[0]) + 52'(tx[1]) + 52'(tx[2]) + 52'(tx[3]);
    assign sy = 52'(ty[0]) + 52'(ty[1]) + 52'(ty[2]) + 52'(ty[3]);
    assign sz = 52'(tz[0]) + 52'(tz[1]) + 52'(tz[2]) + 52'(tz[3]);
    assign sm = 52'(tm[0]) + 52'(tm[1]) + 52'(tm[2]) + 52'(tm[3]);

    function automatic logic signed [31:0] sat52(input logic signed [51:0] v);
        logic signed [31:0] r;
        begin
            if (v > 52'sd2147483647)
            begin
                r = 32'sh7fffffff;
            end
            else if (v < -52'sd2147483648)
            begin
                r = 32'sh80000000;
            end
            else
            begin
                r = sat40(v[39:0]);
            end
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= vld_reg[PIPE_DEPTH-2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x      <= sat52(sx);
            out_y      <= sat52(sy);
            out_z      <= sat52(sz);
            out_margin <= sat52(sm);
        end
    end

`include "linear_blend_skinning_unit_macros.svh"

    `LBS_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, out_valid && $stable(out_x), "output lost while stalled")
    `LBS_ASSERT_IMPL(a_ready_free, !out_valid, in_ready, "input blocked with empty output")
    `LBS_ASSERT_NEXT(a_load_no_out, in_fire && (cmd == CMD_LOAD) && adv, !vld_reg[0], "load produced a result")

endmodule

// File: dv/tb_top.sv
// self-checking testbench of the four-bone skinning unit
`timescale 1ns / 100ps

module tb_top;
    import lbs_pkg::*;

    localparam int NUM_BONES = MAX_BONES_DEF;
    localparam int RANDOM_ITEMS = 1100;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic              cmd;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [16:0]       wa, wb, wc, wd;
        logic [7:0]        ba, bb, bc, bd;
    } vertex_beat_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] margin;
    } blend_t;

    typedef struct packed {
        vertex_beat_t beat;
        logic         typed;
        blend_t       want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic cmd;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [16:0] weight_a, weight_b, weight_c, weight_d;
    logic [7:0] bone_a, bone_b, bone_c, bone_d;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] out_x, out_y, out_z, out_margin;

    linear_blend_skinning_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c), .weight_d(weight_d),
        .bone_a(bone_a), .bone_b(bone_b), .bone_c(bone_c), .bone_d(bone_d),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_margin(out_margin)
    );

    // predictor copy of the bone palette
    logic [31:0] bone_mat [NUM_BONES][WORDS_PER_BONE];
    logic [31:0] bone_margin [NUM_BONES];
    // which palette words the stimulus has written so far
    logic [12:0] word_written [NUM_BONES];
    int ready_bones [$];

    blend_t blend_queue [$];
    bit     typed_queue [$];
    blend_t typed_want [$];

    int beats_in, loads_in, vertices_in, blends_out, mismatches, idle_cycles;
    bit hold_off;
    bit hold_done;
    bit sender_done;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint word_value(logic [31:0] w);
        return longint'(signed'(w));
    endfunction

    // blended position and margin of one vertex beat
    function automatic blend_t blend_vertex(vertex_beat_t b);
        longint acc [4];
        longint coord [3];
        longint row, wt;
        logic [16:0] wts [4];
        logic [7:0] bns [4];
        blend_t r;
        coord[0] = longint'(b.px);
        coord[1] = longint'(b.py);
        coord[2] = longint'(b.pz);
        wts = '{b.wa, b.wb, b.wc, b.wd};
        bns = '{b.ba, b.bb, b.bc, b.bd};
        for (int j = 0; j < 4; j++)
        begin
            acc[j] = 0;
        end
        for (int k = 0; k < 4; k++)
        begin
            wt = longint'(wts[k]);
            if (wt != 0 && int'(bns[k]) < NUM_BONES)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    row = word_value(bone_mat[bns[k]][4 * j + 3]);
                    for (int c = 0; c < 3; c++)
                    begin
                        row += floor16(word_value(bone_mat[bns[k]][4 * j + c]) * coord[c]);
                    end
                    acc[j] += floor16(clamp32(row) * wt);
                end
                acc[3] += floor16(word_value(bone_margin[bns[k]]) * wt);
            end
        end
        r.x = clamp32(acc[0]);
        r.y = clamp32(acc[1]);
        r.z = clamp32(acc[2]);
        r.margin = clamp32(acc[3]);
        return r;
    endfunction

    // input and output monitor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            beats_in++;
            if (cmd == CMD_LOAD)
            begin
                loads_in++;
                if (int'(bone_a) < NUM_BONES)
                begin
                    if (bone_b < WORDS_PER_BONE)
                    begin
                        bone_mat[bone_a][bone_b] = pos_x;
                    end
                    else if (bone_b == WORD_MARGIN)
                    begin
                        bone_margin[bone_a] = pos_x;
                    end
                end
            end
            else
            begin
                vertices_in++;
                blend_queue.push_back(blend_vertex({cmd, pos_x, pos_y, pos_z,
                    weight_a, weight_b, weight_c, weight_d,
                    bone_a, bone_b, bone_c, bone_d}));
            end
        end
        if (rst_n && out_valid && out_ready)
        begin
            blend_t got, want, typed;
            bit has_typed;
            got = '{out_x, out_y, out_z, out_margin};
            if (blend_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected output beat %h %h %h %h",
                        out_x, out_y, out_z, out_margin);
                end
            end
            else
            begin
                want = blend_queue.pop_front();
                has_typed = typed_queue.pop_front();
                if (has_typed)
                begin
                    typed = typed_want.pop_front();
                    if (typed != want)
                    begin
                        want = typed;
                    end
                end
                blends_out++;
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                    || got.margin !== want.margin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch on beat %0d: x %h/%h y %h/%h z %h/%h margin %h/%h",
                            blends_out, want.x, got.x, want.y, got.y, want.z, got.z,
                            want.margin, got.margin);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
        begin
            idle_cycles = 0;
        end
        else if (++idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin
        int mode;
        out_ready = 1'b0;
        hold_off = 1'b0;
        hold_done = 1'b0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 63) == 0)
            begin
                mode = $urandom_range(0, 3);
            end
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ~out_ready;
            endcase
        end
    end

    function automatic logic [31:0] pick_word(bit wide);
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom();
            default: return wide ? $urandom() : 32'(signed'($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    function automatic logic [16:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(0, 255));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom();
        end
        return 32'(signed'($urandom_range(0, 2 ** 25)) - 2 ** 24);
    endfunction

    function automatic vertex_beat_t load_beat(int bone, int word, logic [31:0] val);
        vertex_beat_t b;
        b = '0;
        b.cmd = CMD_LOAD;
        b.px = val;
        b.py = $urandom();
        b.pz = $urandom();
        b.wa = 17'($urandom());
        b.ba = 8'(bone);
        b.bb = 8'(word);
        b.bc = 8'($urandom());
        b.bd = 8'($urandom());
        return b;
    endfunction

    function automatic int pick_ready_bone();
        return ready_bones[$urandom_range(0, ready_bones.size() - 1)];
    endfunction

    // one beat on the input channel, held until accepted
    task automatic offer_beat(vertex_beat_t b);
        int seen;
        in_valid <= 1'b1;
        cmd <= b.cmd;
        pos_x <= b.px;
        pos_y <= b.py;
        pos_z <= b.pz;
        weight_a <= b.wa;
        weight_b <= b.wb;
        weight_c <= b.wc;
        weight_d <= b.wd;
        bone_a <= b.ba;
        bone_b <= b.bb;
        bone_c <= b.bc;
        bone_d <= b.bd;
        seen = beats_in;
        do @(negedge clk); while (beats_in == seen);
        // stimulus-side view of which entries may be read
        if (b.cmd == CMD_LOAD && b.bb <= WORD_MARGIN)
        begin
            if (word_written[b.ba] != 13'h1fff)
            begin
                word_written[b.ba][b.bb] = 1'b1;
                if (word_written[b.ba] == 13'h1fff)
                begin
                    ready_bones.push_back(b.ba);
                end
            end
        end
    endtask

    // burst gaps on the sender side
    task automatic sender_gap(ref int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 40);
        if ($urandom_range(0, 2) != 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic fill_bone(int bone, logic [31:0] vals [13]);
        for (int w = 0; w < 13; w++)
        begin
            offer_beat(load_beat(bone, w, vals[w]));
        end
    endtask

    stim_row_t directed [$];

    initial
    begin
        vertex_beat_t b;
        logic [31:0] vals [13];
        int burst_left;
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_LOAD;
        {pos_x, pos_y, pos_z} = '0;
        {weight_a, weight_b, weight_c, weight_d} = '0;
        {bone_a, bone_b, bone_c, bone_d} = '0;
        beats_in = 0;
        loads_in = 0;
        vertices_in = 0;
        blends_out = 0;
        mismatches = 0;
        idle_cycles = 0;
        sender_done = 1'b0;
        burst_left = 0;
        for (int i = 0; i < NUM_BONES; i++)
        begin
            word_written[i] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // palette setup: identity bone 0, all-max bone 255, all-min bone 128, random 85 and 170
        vals = '{32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0, 32'h10000};
        fill_bone(0, vals);
        vals = '{default: 32'h7fffffff};
        fill_bone(255, vals);
        vals = '{default: 32'h80000000};
        fill_bone(128, vals);
        foreach (vals[w]) vals[w] = pick_word(1'b0);
        fill_bone(85, vals);
        foreach (vals[w]) vals[w] = pick_word(1'b1);
        fill_bone(170, vals);

        // directed rows
        b = '0;
        b.cmd = CMD_SKIN;
        b.px = 32'h10000; b.py = 32'h20000; b.pz = 32'hfffd0000;
        b.wa = 17'd65536;
        directed.push_back('{b, 1'b1, '{32'h10000, 32'h20000, 32'hfffd0000, 32'h10000}});
        b.wa = 0;
        directed.push_back('{b, 1'b1, '{0, 0, 0, 0}});
        b.px = 32'h7fffffff; b.py = 32'h7fffffff; b.pz = 32'h7fffffff;
        b.wa = 17'd65536; b.wb = 17'd65536; b.wc = 17'd65536; b.wd = 17'd65536;
        b.ba = 255; b.bb = 255; b.bc = 255; b.bd = 255;
        directed.push_back('{b, 1'b1,
            '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff}});
        b.px = 32'h80000000; b.py = 32'h80000000; b.pz = 32'h80000000;
        b.ba = 128; b.bb = 128; b.bc = 128; b.bd = 128;
        directed.push_back('{b, 1'b0, '0});
        b.wb = 17'd1; b.wc = 17'd0; b.wd = 17'd32768;
        b.ba = 0; b.bb = 85; b.bc = 255; b.bd = 170;
        directed.push_back('{b, 1'b0, '0});
        // ignored loads: word select past the margin
        directed.push_back('{load_beat(0, 13, 32'hdeadbeef), 1'b0, '0});
        directed.push_back('{load_beat(255, 255, 32'h12345678), 1'b0, '0});
        // overwrite a translation word, then read it back
        directed.push_back('{load_beat(0, 3, 32'h00050000), 1'b0, '0});
        b = '0;
        b.cmd = CMD_SKIN;
        b.wa = 17'd65536;
        directed.push_back('{b, 1'b1, '{32'h50000, 0, 0, 32'h10000}});
        b.wa = 17'd32768; b.wb = 17'd32768; b.wc = 17'd65536; b.wd = 17'd65536;
        b.px = 32'hffffffff; b.py = 32'h1; b.pz = 32'h55555555;
        b.ba = 0; b.bb = 0; b.bc = 85; b.bd = 85;
        directed.push_back('{b, 1'b0, '0});
        b.wa = 17'h0ffff; b.wb = 17'h10000; b.wc = 17'h0aaaa; b.wd = 17'h05555;
        b.ba = 170; b.bb = 85; b.bc = 0; b.bd = 255;
        directed.push_back('{b, 1'b0, '0});
        directed.push_back('{load_beat(0, 3, 32'h0), 1'b0, '0});

        foreach (directed[i])
        begin
            if (directed[i].beat.cmd == CMD_SKIN)
            begin
                typed_queue.push_back(directed[i].typed);
                if (directed[i].typed)
                begin
                    typed_want.push_back(directed[i].want);
                end
            end
            offer_beat(directed[i].beat);
            sender_gap(burst_left);
        end

        // let everything drain before random traffic
        in_valid <= 1'b0;
        wait (blend_queue.size() == 0);
        @(negedge clk);

        // random traffic: mostly vertices over written bones, some loads
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                hold_off = 1'b1;
            end
            if ($urandom_range(0, 9) < 3)
            begin
                pick = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : pick_ready_bone();
                b = load_beat(pick, $urandom_range(0, 15), pick_word($urandom_range(0, 3) == 0));
            end
            else
            begin
                b.cmd = CMD_SKIN;
                b.px = pick_coord();
                b.py = pick_coord();
                b.pz = pick_coord();
                b.wa = pick_weight();
                b.wb = pick_weight();
                b.wc = pick_weight();
                b.wd = pick_weight();
                b.ba = 8'(pick_ready_bone());
                b.bb = 8'(pick_ready_bone());
                b.bc = 8'(pick_ready_bone());
                b.bd = 8'(pick_ready_bone());
            end
            if (b.cmd == CMD_SKIN)
            begin
                typed_queue.push_back(1'b0);
            end
            offer_beat(b);
            sender_gap(burst_left);
        end
        in_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // end of run
    initial
    begin
        wait (sender_done);
        wait (blend_queue.size() == 0);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        $display("covered %0d beats: %0d palette loads, %0d vertices, %0d bones fully written",
            beats_in, loads_in, vertices_in, ready_bones.size());
        $display("checked %0d blended outputs, %0d mismatches", blends_out, mismatches);
        if (mismatches == 0 && blend_queue.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
